// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and byte functions of the aes block cipher
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned NumKeyWords = 60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_LOAD,
        ST_KEY_EXP,
        ST_RD_FIRST,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    typedef enum logic [2:0] {
        REG_KEY_SIZE   = 3'd0,
        REG_CHAIN_MODE = 3'd1,
        REG_KEY_WORD0  = 3'd2,
        REG_KEY_WORD1  = 3'd3,
        REG_KEY_WORD2  = 3'd4,
        REG_KEY_WORD3  = 3'd5,
        REG_IV_HIGH    = 3'd6,
        REG_IV_LOW     = 3'd7
    } aes_reg_t;

    typedef struct packed {
        logic         first;
        logic         last;
        logic         decrypt;
    } aes_round_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

// ===== rtl/aes_round.sv =====
// ----------------------------------------------------------------------------
// aes_round
// one shared cipher round, forward or inverse: add round key, sub bytes, shift rows, mix columns
// ----------------------------------------------------------------------------
module aes_round (
    input  logic [127:0]           state_in,
    input  logic [127:0]           round_key,
    input  aes_pkg::aes_round_ctl_t ctl,
    output logic [127:0]           state_out
);

    logic [7:0]   s [16];
    logic [7:0]   b [16];
    logic [7:0]   m [16];
    logic [127:0] shifted;
    logic [127:0] mixed;
    logic [7:0]   all;
    logic [7:0]   u;
    logic [7:0]   v;
    logic [7:0]   t;
    logic [7:0]   o [4];

    // encrypt round: sb, sr, mc (not on last), ark
    // decrypt round: isr, isb, ark, imc (not on last)
    // first round: only ark
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_in[127 - 8*i -: 8];
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (ctl.decrypt)
                begin
                    b[r + 4*c] = aes_pkg::inv_sbox(s[r + 4*((c + 4 - r) % 4)]);
                end
                else
                begin
                    b[r + 4*c] = aes_pkg::sbox(s[r + 4*((c + r) % 4)]);
                end
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            shifted[127 - 8*i -: 8] = b[i];
        end
        if (ctl.decrypt)
        begin
            shifted = shifted ^ round_key;
        end
        for (int i = 0; i < 16; i++)
        begin
            b[i] = shifted[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            all = b[4*c] ^ b[4*c+1] ^ b[4*c+2] ^ b[4*c+3];
            for (int j = 0; j < 4; j++)
            begin
                o[j] = all ^ b[4*c+j] ^ aes_pkg::gf_double(b[4*c+j] ^ b[4*c+((j+1)%4)]);
            end
            u = aes_pkg::gf_double(aes_pkg::gf_double(b[4*c] ^ b[4*c+2]));
            v = aes_pkg::gf_double(aes_pkg::gf_double(b[4*c+1] ^ b[4*c+3]));
            t = aes_pkg::gf_double(u ^ v);
            if (ctl.decrypt)
            begin
                o[0] = o[0] ^ t ^ u;
                o[1] = o[1] ^ t ^ v;
                o[2] = o[2] ^ t ^ u;
                o[3] = o[3] ^ t ^ v;
            end
            for (int j = 0; j < 4; j++)
            begin
                m[4*c+j] = o[j];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            mixed[127 - 8*i -: 8] = m[i];
        end
        if (ctl.first)
        begin
            state_out = state_in ^ round_key;
        end
        else if (ctl.last)
        begin
            state_out = ctl.decrypt ? shifted : (shifted ^ round_key);
        end
        else
        begin
            state_out = ctl.decrypt ? mixed : (mixed ^ round_key);
        end
    end

endmodule

// ===== rtl/aes_block_cipher_ecb_cbc_top.sv =====
// ----------------------------------------------------------------------------
// aes_block_cipher_ecb_cbc_top
// aes-128/192/256 block cipher, ecb or cbc, with apb register port
// ----------------------------------------------------------------------------
// after a key or key size write the first word also waits for key expansion:
// nk words are loaded, then the rest of the 4*(nr+1) round key words are expanded,
// one round key word a cycle (nr = 10, 12 or 14, nk = 4, 6 or 8)
// one word at a time: a new word is accepted only in idle once the previous
// result has been taken; all rounds run on the single shared round unit
// rst_n clears control state, config registers and the chaining value
module aes_block_cipher_ecb_cbc_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic        new_message,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);

    logic [1:0]   key_size_reg;
    logic         chain_mode_reg;
    logic [63:0]  key_reg [4];
    logic [63:0]  iv_high_reg;
    logic [63:0]  iv_low_reg;
    logic [127:0] chain_reg;
    logic         sched_ok_reg;

    aes_pkg::aes_state_t state_reg, state_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [2:0]   kph_reg, kph_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] blk_reg;
    logic         dec_reg;
    logic         rst_chain_reg;
    logic [7:0]   rcon_reg, rcon_next;
    logic         out_valid_reg, out_valid_next;
    logic [127:0] res_reg, res_next;

    // round key memory, one 32-bit word per cycle
    logic [31:0]  rk_mem [aes_pkg::NumKeyWords];
    logic [31:0]  rk_rd_reg;
    logic [5:0]   rk_raddr;
    logic [3:0]   rnd_rd;
    logic [5:0]   rk_waddr;
    logic [31:0]  rk_wdata;
    logic         rk_we;
    logic [31:0]  win_reg [8];
    logic [95:0]  rkey_reg;
    logic [1:0]   kcol_reg, kcol_next;

    logic         wr_en;
    logic [2:0]   widx;
    logic [3:0]   nr;
    logic [3:0]   nk;
    logic [5:0]   total;
    logic [2:0]   kmod;
    logic [31:0]  tw;
    logic [31:0]  prev_w;
    logic [127:0] chain_cur;
    logic [127:0] rnd_out;
    logic [127:0] ld_blk;
    logic         accept;
    aes_pkg::aes_round_ctl_t rctl;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = paddr[5:3];
    assign accept = in_valid && in_ready;

    always_comb
    begin
        unique case (key_size_reg)
            2'd0:    nr = 4'd10;
            2'd1:    nr = 4'd12;
            default: nr = 4'd14;
        endcase
        unique case (key_size_reg)
            2'd0:    nk = 4'd4;
            2'd1:    nk = 4'd6;
            default: nk = 4'd8;
        endcase
    end
    assign total = {nr, 2'b00} + 6'd4;

    always_comb
    begin
        unique case (aes_pkg::aes_reg_t'(widx))
            aes_pkg::REG_KEY_SIZE:   prdata = {62'd0, key_size_reg};
            aes_pkg::REG_CHAIN_MODE: prdata = {63'd0, chain_mode_reg};
            aes_pkg::REG_KEY_WORD0:  prdata = key_reg[0];
            aes_pkg::REG_KEY_WORD1:  prdata = key_reg[1];
            aes_pkg::REG_KEY_WORD2:  prdata = key_reg[2];
            aes_pkg::REG_KEY_WORD3:  prdata = key_reg[3];
            aes_pkg::REG_IV_HIGH:    prdata = iv_high_reg;
            aes_pkg::REG_IV_LOW:     prdata = iv_low_reg;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg   <= '0;
            chain_mode_reg <= 1'b0;
            key_reg        <= '{default: '0};
            iv_high_reg    <= '0;
            iv_low_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (aes_pkg::aes_reg_t'(widx))
                aes_pkg::REG_KEY_SIZE:   key_size_reg   <= pwdata[1:0];
                aes_pkg::REG_CHAIN_MODE: chain_mode_reg <= pwdata[0];
                aes_pkg::REG_KEY_WORD0:  key_reg[0]     <= pwdata;
                aes_pkg::REG_KEY_WORD1:  key_reg[1]     <= pwdata;
                aes_pkg::REG_KEY_WORD2:  key_reg[2]     <= pwdata;
                aes_pkg::REG_KEY_WORD3:  key_reg[3]     <= pwdata;
                aes_pkg::REG_IV_HIGH:    iv_high_reg    <= pwdata;
                aes_pkg::REG_IV_LOW:     iv_low_reg     <= pwdata;
                default:                 iv_low_reg     <= iv_low_reg;
            endcase
        end
    end

    // key expansion word from the sliding window of the last nk words
    // kph_reg runs through the word index modulo nk
    assign prev_w = win_reg[nk[2:0] - 3'd1];
    assign kmod   = kph_reg;
    always_comb
    begin
        tw = prev_w;
        if (kmod == 3'd0)
        begin
            tw = aes_pkg::sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_reg, 24'd0};
        end
        else if (nk == 4'd8 && kmod == 3'd4)
        begin
            tw = aes_pkg::sub_word(prev_w);
        end
    end

    always_comb
    begin
        rk_we    = 1'b0;
        rk_waddr = cnt_reg;
        rk_wdata = win_reg[0] ^ tw;
        if (state_reg == aes_pkg::ST_KEY_LOAD)
        begin
            rk_we    = 1'b1;
            rk_wdata = cnt_reg[0] ? key_reg[cnt_reg[2:1]][31:0]
                                  : key_reg[cnt_reg[2:1]][63:32];
        end
        else if (state_reg == aes_pkg::ST_KEY_EXP)
        begin
            rk_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[rk_waddr] <= rk_wdata;
        end
        rk_rd_reg <= rk_mem[rk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            for (int i = 0; i < 7; i++)
            begin
                win_reg[i] <= (3'(i) == nk[2:0] - 3'd1) ? rk_wdata : win_reg[i+1];
            end
            win_reg[7] <= rk_wdata;
        end
    end

    // round key read: four words per round, column by column
    // the next round's column 0 is addressed in the cycle its round ends
    always_comb
    begin
        rnd_rd = rnd_reg;
        if (state_reg == aes_pkg::ST_ROUND && kcol_reg == 2'd0 && !rctl.last)
        begin
            rnd_rd = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
        end
        rk_raddr = {rnd_rd, kcol_reg};
    end

    assign chain_cur = rst_chain_reg ? {iv_high_reg, iv_low_reg} : chain_reg;
    assign ld_blk    = {block_high, block_low};

    assign rctl.first     = dec_reg ? (rnd_reg == nr) : (rnd_reg == 4'd0);
    assign rctl.last      = dec_reg ? (rnd_reg == 4'd0) : (rnd_reg == nr);
    assign rctl.decrypt   = dec_reg;

    aes_round u_round (
        .state_in  (st_reg),
        .round_key ({rkey_reg, rk_rd_reg}),
        .ctl       (rctl),
        .state_out (rnd_out)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        kph_next       = kph_reg;
        rnd_next       = rnd_reg;
        kcol_next      = kcol_reg;
        st_next        = st_reg;
        rcon_next      = rcon_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            aes_pkg::ST_IDLE:
            begin
                in_ready = !out_valid_reg;
                if (accept)
                begin
                    cnt_next  = '0;
                    kph_next  = '0;
                    rcon_next = 8'h01;
                    rnd_next  = kind ? nr : 4'd0;
                    kcol_next = '0;
                    state_next = sched_ok_reg ? aes_pkg::ST_RD_FIRST : aes_pkg::ST_KEY_LOAD;
                end
            end
            aes_pkg::ST_KEY_LOAD:
            begin
                cnt_next = cnt_reg + 6'd1;
                kph_next = (kph_reg == nk[2:0] - 3'd1) ? 3'd0 : kph_reg + 3'd1;
                if (cnt_reg == 6'(nk) - 6'd1)
                begin
                    state_next = aes_pkg::ST_KEY_EXP;
                end
            end
            aes_pkg::ST_KEY_EXP:
            begin
                cnt_next = cnt_reg + 6'd1;
                kph_next = (kph_reg == nk[2:0] - 3'd1) ? 3'd0 : kph_reg + 3'd1;
                if (kmod == 3'd0)
                begin
                    rcon_next = aes_pkg::gf_double(rcon_reg);
                end
                if (cnt_reg == total - 6'd1)
                begin
                    state_next = aes_pkg::ST_RD_FIRST;
                end
            end
            aes_pkg::ST_RD_FIRST:
            begin
                kcol_next  = kcol_reg + 2'd1;
                state_next = aes_pkg::ST_ROUND;
            end
            aes_pkg::ST_ROUND:
            begin
                kcol_next = kcol_reg + 2'd1;
                if (kcol_reg == 2'd0)
                begin
                    st_next = rnd_out;
                    if (rctl.last)
                    begin
                        state_next = aes_pkg::ST_DONE;
                    end
                    else
                    begin
                        rnd_next = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                    end
                end
            end
            aes_pkg::ST_DONE:
            begin
                out_valid_next = 1'b1;
                if (dec_reg && chain_mode_reg)
                begin
                    res_next = st_reg ^ chain_cur;
                end
                else
                begin
                    res_next = st_reg;
                end
                state_next = aes_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = aes_pkg::ST_IDLE;
            end
        endcase
    end

    // the read data of column 3 lands as column 0 is addressed again
    always_ff @(posedge clk)
    begin
        unique case (kcol_reg)
            2'd1:    rkey_reg[95:64] <= rk_rd_reg;
            2'd2:    rkey_reg[63:32] <= rk_rd_reg;
            2'd3:    rkey_reg[31:0]  <= rk_rd_reg;
            default: rkey_reg        <= rkey_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aes_pkg::ST_IDLE;
            cnt_reg       <= '0;
            kph_reg       <= '0;
            rnd_reg       <= '0;
            kcol_reg      <= '0;
            rcon_reg      <= 8'h01;
            out_valid_reg <= 1'b0;
            sched_ok_reg  <= 1'b0;
            chain_reg     <= '0;
            rst_chain_reg <= 1'b0;
            dec_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            kph_reg       <= kph_next;
            rnd_reg       <= rnd_next;
            kcol_reg      <= kcol_next;
            rcon_reg      <= rcon_next;
            out_valid_reg <= out_valid_next;
            if (wr_en && (widx == aes_pkg::REG_KEY_SIZE || widx == aes_pkg::REG_KEY_WORD0 ||
                          widx == aes_pkg::REG_KEY_WORD1 || widx == aes_pkg::REG_KEY_WORD2 ||
                          widx == aes_pkg::REG_KEY_WORD3))
            begin
                sched_ok_reg <= 1'b0;
            end
            else if (state_reg == aes_pkg::ST_KEY_EXP && state_next == aes_pkg::ST_RD_FIRST)
            begin
                sched_ok_reg <= 1'b1;
            end
            if (accept)
            begin
                dec_reg       <= kind;
                rst_chain_reg <= new_message;
            end
            if (state_reg == aes_pkg::ST_DONE)
            begin
                rst_chain_reg <= 1'b0;
                if (chain_mode_reg)
                begin
                    chain_reg <= dec_reg ? blk_reg : st_reg;
                end
                else
                begin
                    chain_reg <= chain_cur;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            blk_reg <= ld_blk;
            if (!kind && chain_mode_reg)
            begin
                st_reg <= ld_blk ^ (new_message ? {iv_high_reg, iv_low_reg} : chain_reg);
            end
            else
            begin
                st_reg <= ld_blk;
            end
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_high = res_reg[127:64];
    assign result_low  = res_reg[63:0];

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == aes_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == aes_pkg::ST_DONE |=> out_valid)
        else $error("result not presented");
    a_sched_before_round: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == aes_pkg::ST_ROUND |-> sched_ok_reg || wr_en || $past(wr_en))
        else $error("round without key schedule");

endmodule
